FILE: hdl/rbm_pkg.sv
// Shared types and codes for the radius block membership block.
package rbm_pkg;

    localparam logic [1:0] ACT_LOAD_NODE  = 2'd0;
    localparam logic [1:0] ACT_LOAD_BLOCK = 2'd1;
    localparam logic [1:0] ACT_QUERY      = 2'd2;
    localparam logic [1:0] ACT_UNUSED     = 2'd3;

    localparam logic [1:0] REG_RADIUS        = 2'd0;
    localparam logic [1:0] REG_NODES_IN_USE  = 2'd1;
    localparam logic [1:0] REG_BLOCKS_IN_USE = 2'd2;

    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 23;
    localparam int LIM_W    = 2 * RADIUS_W;
    localparam int IDX_W    = 10;
    localparam int CNT17_W  = 17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BRD,
        ST_BCNT,
        ST_BCHK,
        ST_EMIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic valid;
        logic near;
    } flag_t;

endpackage

FILE: hdl/radius_block_membership_top.sv
// Top level of the radius block membership block: control, block table, result register.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    action entry_index pos_x pos_y pos_z range_first range_final
//  m_       out  m_valid/m_ready    member_id hit last
//  cfg_     in   cfg_wr_en          cfg_index cfg_wdata
//
// A query scans the nodes in use (one node memory read per cycle, four-stage distance
// pipe), then for each block in use reads the block table and the prefix counts and checks
// the block, with one more emit step per member block after the first, and then finishes.
// Input is held off until a query ends.
// Reset is synchronous; memories hold no reset state. Results stall on m_ready.
module radius_block_membership_top #(
    parameter int NUM_NODES  = 1024,
    parameter int NUM_BLOCKS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [9:0]  s_entry_index,
    input  logic signed [23:0] s_pos_x,
    input  logic signed [23:0] s_pos_y,
    input  logic signed [23:0] s_pos_z,
    input  logic [9:0]  s_range_first,
    input  logic [9:0]  s_range_final,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_member_id,
    output logic        m_hit,
    output logic        m_last
);
    localparam int NODE_AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int CAW     = $clog2(NUM_NODES + 1);
    localparam int BAW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int NW      = rbm_pkg::CNT17_W;
    localparam int IW      = rbm_pkg::IDX_W;

    rbm_pkg::state_t state_reg, state_next;

    logic [22:0]  radius_reg;
    logic [10:0]  nodes_reg;
    logic [6:0]   blocks_reg;
    logic [rbm_pkg::LIM_W-1:0] lim_reg;
    logic signed [23:0] qx_reg, qy_reg, qz_reg;
    logic [NW-1:0] j_reg, k_reg;
    logic [CAW-1:0] cnt_reg;
    logic [6:0]   i_reg;
    logic [6:0]   cur_id_reg, pend_id_reg;
    logic         pend_reg;
    logic         blk_ok_reg, s_zero_reg;
    logic         m_valid_reg, m_hit_reg, m_last_reg;
    logic [6:0]   m_id_reg;

    logic [2*IW-1:0] blk_mem [NUM_BLOCKS];
    logic [2*IW-1:0] blk_rd_reg;

    logic [NW-1:0] nn;
    logic [6:0]    nb;
    logic          in_acc, out_free;
    logic          issue, blk_rd, cnt_rd, load_out, blk_hit, more_blocks;
    logic [NW-1:0] s17, e17, e_cl;
    logic [CAW-1:0] lo_cnt;
    logic [CAW-1:0] rd_a, rd_b;
    rbm_pkg::flag_t flag;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        nn = (NW'(nodes_reg) > NW'(NUM_NODES)) ? NW'(NUM_NODES) : NW'(nodes_reg);
        nb = (blocks_reg > 7'(NUM_BLOCKS)) ? 7'(NUM_BLOCKS) : blocks_reg;
        s17 = NW'(blk_rd_reg[2*IW-1:IW]);
        e17 = NW'(blk_rd_reg[IW-1:0]);
        e_cl = (e17 >= nn) ? (nn - NW'(1)) : e17;
        lo_cnt = s_zero_reg ? '0 : rd_a;
        blk_hit = blk_ok_reg && (rd_b != lo_cnt);
        more_blocks = (i_reg + 7'd1) < nb;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rbm_pkg::ST_IDLE: begin
                if (in_acc && s_action == rbm_pkg::ACT_QUERY) begin
                    state_next = rbm_pkg::ST_SCAN;
                end
            end
            rbm_pkg::ST_SCAN: begin
                if (j_reg == nn && k_reg == nn) begin
                    state_next = (nb == 7'd0) ? rbm_pkg::ST_FIN : rbm_pkg::ST_BRD;
                end
            end
            rbm_pkg::ST_BRD:  state_next = rbm_pkg::ST_BCNT;
            rbm_pkg::ST_BCNT: state_next = rbm_pkg::ST_BCHK;
            rbm_pkg::ST_BCHK: begin
                if (blk_hit && pend_reg) begin
                    state_next = rbm_pkg::ST_EMIT;
                end else begin
                    state_next = more_blocks ? rbm_pkg::ST_BRD : rbm_pkg::ST_FIN;
                end
            end
            rbm_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = more_blocks ? rbm_pkg::ST_BRD : rbm_pkg::ST_FIN;
                end
            end
            rbm_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = rbm_pkg::ST_IDLE;
                end
            end
            default: state_next = rbm_pkg::ST_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        s_ready  = 1'b0;
        issue    = 1'b0;
        blk_rd   = 1'b0;
        cnt_rd   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            rbm_pkg::ST_IDLE: s_ready  = 1'b1;
            rbm_pkg::ST_SCAN: issue    = j_reg < nn;
            rbm_pkg::ST_BRD:  blk_rd   = 1'b1;
            rbm_pkg::ST_BCNT: cnt_rd   = 1'b1;
            rbm_pkg::ST_EMIT: load_out = out_free;
            rbm_pkg::ST_FIN:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_action == rbm_pkg::ACT_LOAD_BLOCK &&
            s_entry_index < IW'(NUM_BLOCKS)) begin
            blk_mem[s_entry_index[BAW-1:0]] <= {s_range_first, s_range_final};
        end
        if (blk_rd) begin
            blk_rd_reg <= blk_mem[i_reg[BAW-1:0]];
        end
    end

    rbm_dist_pipe #(
        .NUM_NODES (NUM_NODES),
        .NODE_AW   (NODE_AW)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_en   (in_acc && s_action == rbm_pkg::ACT_LOAD_NODE &&
                    NW'(s_entry_index) < NW'(NUM_NODES)),
        .load_addr (NODE_AW'(s_entry_index)),
        .load_x    (s_pos_x),
        .load_y    (s_pos_y),
        .load_z    (s_pos_z),
        .rd_en     (issue),
        .rd_addr   (j_reg[NODE_AW-1:0]),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .qz        (qz_reg),
        .lim       (lim_reg),
        .flag      (flag)
    );

    rbm_count_mem #(
        .DEPTH (NUM_NODES + 1),
        .AW    (CAW)
    ) u_cnt (
        .aclk      (aclk),
        .wr_en     (flag.valid),
        .wr_addr   (CAW'(k_reg + NW'(1))),
        .wr_data   (cnt_reg + CAW'(flag.near)),
        .rd_en     (cnt_rd),
        .rd_addr_a (CAW'(s17)),
        .rd_addr_b (CAW'(e_cl + NW'(1))),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rbm_pkg::ST_IDLE;
            radius_reg  <= 23'd25600;
            nodes_reg   <= '0;
            blocks_reg  <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            j_reg       <= '0;
            k_reg       <= '0;
            cnt_reg     <= '0;
            i_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rbm_pkg::REG_RADIUS:        radius_reg <= cfg_wdata;
                    rbm_pkg::REG_NODES_IN_USE:  nodes_reg  <= cfg_wdata[10:0];
                    rbm_pkg::REG_BLOCKS_IN_USE: blocks_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (in_acc && s_action == rbm_pkg::ACT_QUERY) begin
                j_reg    <= '0;
                k_reg    <= '0;
                cnt_reg  <= '0;
                i_reg    <= '0;
                pend_reg <= 1'b0;
            end
            if (issue) begin
                j_reg <= j_reg + NW'(1);
            end
            if (flag.valid) begin
                k_reg   <= k_reg + NW'(1);
                cnt_reg <= cnt_reg + CAW'(flag.near);
            end
            if (state_reg == rbm_pkg::ST_BCHK) begin
                if (blk_hit && !pend_reg) begin
                    pend_reg <= 1'b1;
                end
                if (!(blk_hit && pend_reg)) begin
                    i_reg <= i_reg + 7'd1;
                end
            end
            if (state_reg == rbm_pkg::ST_EMIT && out_free) begin
                i_reg <= i_reg + 7'd1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_action == rbm_pkg::ACT_QUERY) begin
            qx_reg  <= s_pos_x;
            qy_reg  <= s_pos_y;
            qz_reg  <= s_pos_z;
            lim_reg <= radius_reg * radius_reg;
        end
        if (cnt_rd) begin
            blk_ok_reg <= (s17 <= e17) && (s17 < nn);
            s_zero_reg <= (s17 == '0);
            cur_id_reg <= i_reg + 7'd1;
        end
        if (state_reg == rbm_pkg::ST_BCHK && blk_hit && !pend_reg) begin
            pend_id_reg <= cur_id_reg;
        end
        if (state_reg == rbm_pkg::ST_EMIT && out_free) begin
            m_id_reg    <= pend_id_reg;
            m_hit_reg   <= 1'b1;
            m_last_reg  <= 1'b0;
            pend_id_reg <= cur_id_reg;
        end
        if (state_reg == rbm_pkg::ST_FIN && out_free) begin
            m_id_reg   <= pend_reg ? pend_id_reg : 7'd0;
            m_hit_reg  <= pend_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_member_id = m_id_reg;
    assign m_hit       = m_hit_reg;
    assign m_last      = m_last_reg;

    a_flag_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        flag.valid |-> state_reg == rbm_pkg::ST_SCAN)
        else $error("distance result outside node scan");
    a_k_le_j: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rbm_pkg::ST_SCAN |-> k_reg <= j_reg)
        else $error("more flags than node reads");
    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rbm_pkg::ST_FIN && out_free) |=> state_reg == rbm_pkg::ST_IDLE)
        else $error("query did not finish after last item");
    a_miss_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_last && m_member_id == 7'd0))
        else $error("miss item not final");

endmodule

FILE: hdl/rbm_dist_pipe.sv
// Node position memory and four-stage squared-distance compare pipeline.
module rbm_dist_pipe #(
    parameter int NUM_NODES = 1024,
    parameter int NODE_AW   = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load_en,
    input  logic [NODE_AW-1:0]                load_addr,
    input  logic signed [rbm_pkg::COORD_W-1:0] load_x,
    input  logic signed [rbm_pkg::COORD_W-1:0] load_y,
    input  logic signed [rbm_pkg::COORD_W-1:0] load_z,
    input  logic                              rd_en,
    input  logic [NODE_AW-1:0]                rd_addr,
    input  logic signed [rbm_pkg::COORD_W-1:0] qx,
    input  logic signed [rbm_pkg::COORD_W-1:0] qy,
    input  logic signed [rbm_pkg::COORD_W-1:0] qz,
    input  logic [rbm_pkg::LIM_W-1:0]          lim,
    output rbm_pkg::flag_t                     flag
);
    localparam int CW = rbm_pkg::COORD_W;

    logic [3*CW-1:0] node_mem [NUM_NODES];
    logic [3*CW-1:0] rd_data_reg;
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CW-1:0]   ax_reg, ay_reg, az_reg;
    logic [2*CW-1:0] sx_reg, sy_reg, sz_reg;
    logic            near_reg;

    logic signed [CW:0] dx, dy, dz;
    logic [CW:0]        mx, my, mz;
    logic [2*CW+1:0]    d2;

    always_ff @(posedge aclk) begin
        if (load_en) begin
            node_mem[load_addr] <= {load_x, load_y, load_z};
        end
        if (rd_en) begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    always_comb begin
        dx = {qx[CW-1], qx} - {rd_data_reg[3*CW-1], rd_data_reg[3*CW-1:2*CW]};
        dy = {qy[CW-1], qy} - {rd_data_reg[2*CW-1], rd_data_reg[2*CW-1:CW]};
        dz = {qz[CW-1], qz} - {rd_data_reg[CW-1], rd_data_reg[CW-1:0]};
        mx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
        my = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
        mz = dz[CW] ? (CW+1)'(-dz) : (CW+1)'(dz);
        d2 = {2'b00, sx_reg} + {2'b00, sy_reg} + {2'b00, sz_reg};
    end

    always_ff @(posedge aclk) begin
        ax_reg   <= mx[CW-1:0];
        ay_reg   <= my[CW-1:0];
        az_reg   <= mz[CW-1:0];
        sx_reg   <= ax_reg * ax_reg;
        sy_reg   <= ay_reg * ay_reg;
        sz_reg   <= az_reg * az_reg;
        near_reg <= d2 <= {{(2*CW+2-rbm_pkg::LIM_W){1'b0}}, lim};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign flag.valid = v4_reg;
    assign flag.near  = near_reg;

endmodule

FILE: hdl/rbm_count_mem.sv
// Prefix flag count memory: one write port, two registered read ports.
module rbm_count_mem #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [AW-1:0] rd_data_a,
    output logic [AW-1:0] rd_data_b
);
    logic [AW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: bench/tb_radius_block_membership_top.sv
// Self-checking testbench for the radius block membership block: loads, queries, registers.
module tb_radius_block_membership_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NN = 1024;
    localparam int NB = 64;

    typedef struct packed {
        logic [6:0] member_id;
        logic       hit;
        logic       last;
    } member_t;

    class member_board;
        logic signed [23:0] nx[NN], ny[NN], nz[NN];
        logic [9:0] bstart[NB], bend[NB];
        logic [22:0] radius;
        logic [10:0] nodes_used;
        logic [6:0] blocks_used;
        member_t pending[$];
        int errors;

        function new();
            radius = 23'd25600;
            nodes_used = '0;
            blocks_used = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [22:0] v);
            unique case (idx)
                rbm_pkg::REG_RADIUS: radius = v;
                rbm_pkg::REG_NODES_IN_USE: nodes_used = v[10:0];
                rbm_pkg::REG_BLOCKS_IN_USE: blocks_used = v[6:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic [1:0] act, logic [9:0] idx, logic signed [23:0] x,
                                logic signed [23:0] y, logic signed [23:0] z,
                                logic [9:0] rf, logic [9:0] rl);
            int nn, nb, cnt, hits;
            logic [63:0] lim, d2, dx, dy, dz;
            bit near[NN];
            member_t r;
            if (act == rbm_pkg::ACT_LOAD_NODE) begin
                nx[idx] = x; ny[idx] = y; nz[idx] = z;
                return;
            end
            if (act == rbm_pkg::ACT_LOAD_BLOCK) begin
                if (idx < NB) begin
                    bstart[idx] = rf; bend[idx] = rl;
                end
                return;
            end
            if (act != rbm_pkg::ACT_QUERY) return;
            nn = (int'(nodes_used) > NN) ? NN : int'(nodes_used);
            nb = (int'(blocks_used) > NB) ? NB : int'(blocks_used);
            lim = 64'(radius) * 64'(radius);
            for (int j = 0; j < NN; j++) begin
                near[j] = 0;
                if (j < nn) begin
                    dx = 64'(longint'(x) - longint'(nx[j]));
                    dy = 64'(longint'(y) - longint'(ny[j]));
                    dz = 64'(longint'(z) - longint'(nz[j]));
                    if ($signed(dx) < 0) dx = -dx;
                    if ($signed(dy) < 0) dy = -dy;
                    if ($signed(dz) < 0) dz = -dz;
                    d2 = dx * dx + dy * dy + dz * dz;
                    near[j] = (d2 <= lim);
                end
            end
            hits = 0;
            for (int i = 0; i < nb; i++) begin
                int s, e;
                s = int'(bstart[i]); e = int'(bend[i]);
                if (s > e || s >= nn) continue;
                if (e >= nn) e = nn - 1;
                cnt = 0;
                for (int j = s; j <= e; j++) cnt += int'(near[j]);
                if (cnt != 0) begin
                    r.member_id = 7'(i + 1); r.hit = 1'b1; r.last = 1'b0;
                    pending.insert(pending.size(), r);
                    hits++;
                end
            end
            if (hits == 0) begin
                r.member_id = '0; r.hit = 1'b0; r.last = 1'b1;
                pending.insert(pending.size(), r);
            end else begin
                pending[pending.size() - 1].last = 1'b1;
            end
        endfunction

        task report_mismatch(string what, member_t want, member_t got);
            errors++;
            $display("mismatch %s: want id=%0d hit=%0d last=%0d got id=%0d hit=%0d last=%0d",
                     what, want.member_id, want.hit, want.last,
                     got.member_id, got.hit, got.last);
        endtask

        task check_result(member_t got);
            member_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.member_id !== want.member_id) report_mismatch("member_id", want, got);
            if (got.hit !== want.hit) report_mismatch("hit", want, got);
            if (got.last !== want.last) report_mismatch("last", want, got);
        endtask
    endclass

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [22:0] cfg_wdata;
    logic s_valid, s_ready;
    logic [1:0] s_action;
    logic [9:0] s_entry_index, s_range_first, s_range_final;
    logic signed [23:0] s_pos_x, s_pos_y, s_pos_z;
    logic m_valid, m_ready;
    logic [6:0] m_member_id;
    logic m_hit, m_last;

    radius_block_membership_top dut (.*);

    member_board board;
    bit quiet;       // no idling in the last part
    bit hold_off;    // long receiver stall
    int cycles;

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    task automatic write_reg(logic [1:0] idx, logic [22:0] v);
        @(negedge aclk);
        s_valid <= 0;
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
        board.set_reg(idx, v);
    endtask

    task automatic send_item(logic [1:0] act, logic [9:0] idx, logic signed [23:0] x,
                             logic signed [23:0] y, logic signed [23:0] z,
                             logic [9:0] rf, logic [9:0] rl);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1; s_action <= act; s_entry_index <= idx;
        s_pos_x <= x; s_pos_y <= y; s_pos_z <= z;
        s_range_first <= rf; s_range_final <= rl;
        do @(posedge aclk); while (!s_ready);
        board.note_item(act, idx, x, y, z, rf, rl);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (1200) @(negedge aclk);
    endtask

    function automatic logic signed [23:0] near_coord(logic signed [23:0] c);
        return c + 24'($signed($urandom_range(0, 30000)) - 15000);
    endfunction

    // small node set, clustered for hits
    task automatic load_scene(int nodes, int blocks);
        for (int j = 0; j < nodes; j++)
            send_item(rbm_pkg::ACT_LOAD_NODE, 10'(j),
                      24'($signed($urandom_range(0, 80000)) - 40000),
                      24'($signed($urandom_range(0, 80000)) - 40000),
                      24'($signed($urandom_range(0, 80000)) - 40000), 10'($urandom), 10'($urandom));
        for (int i = 0; i < blocks; i++) begin
            int a, b;
            a = $urandom_range(0, nodes + 4);
            b = $urandom_range(0, 5) == 0 ? $urandom_range(0, a) : a + $urandom_range(0, 8);
            send_item(rbm_pkg::ACT_LOAD_BLOCK, 10'(i), 24'($urandom), 24'($urandom),
                      24'($urandom), 10'(a), 10'(b));
        end
    endtask

    task automatic random_query(int nodes);
        int k;
        k = $urandom_range(0, nodes - 1);
        if ($urandom_range(0, 4) == 0)
            send_item(rbm_pkg::ACT_QUERY, 10'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), 10'($urandom), 10'($urandom));
        else
            send_item(rbm_pkg::ACT_QUERY, 10'($urandom), near_coord(board.nx[k]),
                      near_coord(board.ny[k]), near_coord(board.nz[k]),
                      10'($urandom), 10'($urandom));
    endtask

    initial begin
        board = new();
        aresetn = 0; cfg_wr_en = 0; cfg_index = rbm_pkg::REG_RADIUS; cfg_wdata = '0;
        s_valid = 0; s_action = rbm_pkg::ACT_LOAD_NODE; s_entry_index = '0;
        s_pos_x = '0; s_pos_y = '0; s_pos_z = '0; s_range_first = '0; s_range_final = '0;
        quiet = 0; hold_off = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: nothing in use, extremes, ignored codes
        send_item(rbm_pkg::ACT_QUERY, 10'd0, 24'sh7FFFFF, -24'sh800000, 24'sd0, 10'd0, 10'd0);
        send_item(rbm_pkg::ACT_UNUSED, 10'h3FF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                  10'h3FF, 10'h3FF);
        send_item(rbm_pkg::ACT_LOAD_NODE, 10'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                  10'd0, 10'd0);
        send_item(rbm_pkg::ACT_LOAD_NODE, 10'd1, -24'sh800000, -24'sh800000, -24'sh800000,
                  10'd0, 10'd0);
        send_item(rbm_pkg::ACT_LOAD_NODE, 10'h3FF, 24'sd0, 24'sd0, 24'sd0, 10'd0, 10'd0);
        send_item(rbm_pkg::ACT_LOAD_NODE, 10'd2, 24'sd100, -24'sd100, 24'sd0, 10'd0, 10'd0);
        send_item(rbm_pkg::ACT_LOAD_NODE, 10'd3, 24'sd0, 24'sd0, 24'sd0, 10'd0, 10'd0);
        send_item(rbm_pkg::ACT_LOAD_BLOCK, 10'd0, 24'sd0, 24'sd0, 24'sd0, 10'd0, 10'd0);
        send_item(rbm_pkg::ACT_LOAD_BLOCK, 10'd1, 24'sd0, 24'sd0, 24'sd0, 10'd1, 10'd2);
        send_item(rbm_pkg::ACT_LOAD_BLOCK, 10'd2, 24'sd0, 24'sd0, 24'sd0, 10'd2, 10'd1);
        send_item(rbm_pkg::ACT_LOAD_BLOCK, 10'd3, 24'sd0, 24'sd0, 24'sd0, 10'h3FE, 10'h3FF);
        send_item(rbm_pkg::ACT_LOAD_BLOCK, 10'h3FF, 24'sd0, 24'sd0, 24'sd0, 10'd5, 10'd5);
        send_item(rbm_pkg::ACT_LOAD_BLOCK, 10'd63, 24'sd0, 24'sd0, 24'sd0, 10'd0, 10'h3FF);
        for (int i = 4; i < 63; i++)
            send_item(rbm_pkg::ACT_LOAD_BLOCK, 10'(i), 24'sd0, 24'sd0, 24'sd0,
                      10'(i % 5), 10'(i % 5 + i % 3));
        write_reg(rbm_pkg::REG_NODES_IN_USE, 23'd4);
        write_reg(rbm_pkg::REG_BLOCKS_IN_USE, 23'h7F);           // saturates
        write_reg(rbm_pkg::REG_RADIUS, 23'h7FFFFF);
        send_item(rbm_pkg::ACT_QUERY, 10'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                  10'd0, 10'd0);
        send_item(rbm_pkg::ACT_QUERY, 10'd0, -24'sh800000, -24'sh800000, -24'sh800000,
                  10'd0, 10'd0);
        drain();
        write_reg(rbm_pkg::REG_RADIUS, 23'd0);
        send_item(rbm_pkg::ACT_QUERY, 10'd0, 24'sd100, -24'sd100, 24'sd0, 10'd0, 10'd0);
        send_item(rbm_pkg::ACT_QUERY, 10'd0, 24'sh7FFFFF, 24'sd0, 24'sd0, 10'd0, 10'd0);
        drain();
        write_reg(rbm_pkg::REG_RADIUS, 23'd25600);
        send_item(rbm_pkg::ACT_QUERY, 10'd0, 24'sd0, 24'sd0, 24'sd0, 10'd0, 10'd0);
        drain();

        // random phases over a small scene
        for (int ph = 0; ph < 3; ph++) begin
            int nodes, blocks;
            nodes = $urandom_range(6, 14);
            blocks = $urandom_range(3, 6);
            if (ph == 2) quiet = 1;
            write_reg(rbm_pkg::REG_NODES_IN_USE, 23'(nodes - int'($urandom_range(0, 1))));
            write_reg(rbm_pkg::REG_BLOCKS_IN_USE,
                      23'($urandom_range(0, 1) ? blocks : blocks + 2));
            write_reg(rbm_pkg::REG_RADIUS, 23'($urandom_range(0, 3) == 0 ?
                                               $urandom_range(0, 30000) :
                                               $urandom_range(5000, 20000)));
            load_scene(nodes, blocks + 2);
            if (ph == 1) hold_off = 1;
            for (int q = 0; q < 9; q++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(rbm_pkg::ACT_UNUSED, 10'($urandom), 24'($urandom),
                              24'($urandom), 24'($urandom), 10'($urandom), 10'($urandom));
                random_query(nodes);
            end
            drain();
        end
        drain();
        if (board.errors == 0)
            $display("[radius_block_membership_top] OK");
        else
            $display("[radius_block_membership_top] ERROR");
        $finish;
    end

    // receiver
    initial begin
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (3000) @(negedge aclk);
                hold_off = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_member_id, m_hit, m_last});
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 900000) begin
                $display("[radius_block_membership_top] ERROR");
                $finish;
            end
        end
    end
endmodule
